// ===== design/erm_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Euler rotation matrix package
// Shared widths, fixed-point constants, CORDIC arctangent table and helpers.
// ---------------------------------------------------------------------------
package erm_pkg;

    localparam int ANGLE_WIDTH_DEF       = 16;
    localparam int ELEMENT_FRAC_BITS_DEF = 14;
    localparam int TRIG_STAGES_DEF       = 16;

    localparam int QI         = 30;
    localparam int QW         = 34;
    localparam int MAX_STAGES = 32;

    typedef logic signed [QW-1:0] q30_t;

    localparam q30_t PI_Q30      = 34'sd3373259426;
    localparam q30_t HALF_PI_Q30 = 34'sd1686629713;
    localparam q30_t GAIN_Q30    = 34'sd652032874;

    typedef struct packed {
        q30_t x;
        q30_t y;
        q30_t z;
        logic flip;
    } cord_t;

    function automatic q30_t atan_q30(input int i);
        q30_t r;
        case (i)
            0:  r = 34'sd843314856;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043836;
            3:  r = 34'sd133525158;
            4:  r = 34'sd66869110;
            5:  r = 34'sd33471835;
            6:  r = 34'sd16775850;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194282;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048575;
            11: r = 34'sd524287;
            12: r = 34'sd262143;
            13: r = 34'sd131071;
            14: r = 34'sd65535;
            15: r = 34'sd32767;
            16: r = 34'sd16383;
            17: r = 34'sd8191;
            18: r = 34'sd4095;
            19: r = 34'sd2047;
            20: r = 34'sd1023;
            21: r = 34'sd511;
            22: r = 34'sd255;
            23: r = 34'sd127;
            24: r = 34'sd63;
            25: r = 34'sd31;
            26: r = 34'sd15;
            27: r = 34'sd8;
            28: r = 34'sd4;
            29: r = 34'sd2;
            30: r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Q30 product with round half up and arithmetic shift back to Q30.
    function automatic q30_t mulq(input q30_t a, input q30_t b);
        logic signed [2*QW-1:0] p;
        p = a * b;
        p = p + (68'sd1 <<< (QI - 1));
        return p[QI+QW-1:QI];
    endfunction

endpackage
`default_nettype wire

// ===== design/erm_cordic_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// CORDIC cell
// One rotation-mode micro-rotation for the yaw, pitch and roll lanes.
// ---------------------------------------------------------------------------
module erm_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire erm_pkg::cord_t [2:0]   in_data,
    output logic                        out_valid,
    output erm_pkg::cord_t [2:0]        out_data
);

    localparam erm_pkg::q30_t ATAN = erm_pkg::atan_q30(STAGE);

    logic                 valid_reg;
    erm_pkg::cord_t [2:0] data_reg;
    erm_pkg::cord_t [2:0] data_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            data_next[k].flip = in_data[k].flip;
            if (!in_data[k].z[erm_pkg::QW-1])
            begin
                data_next[k].x = in_data[k].x - (in_data[k].y >>> STAGE);
                data_next[k].y = in_data[k].y + (in_data[k].x >>> STAGE);
                data_next[k].z = in_data[k].z - ATAN;
            end
            else
            begin
                data_next[k].x = in_data[k].x + (in_data[k].y >>> STAGE);
                data_next[k].y = in_data[k].y - (in_data[k].x >>> STAGE);
                data_next[k].z = in_data[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ===== design/erm_trig.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Sine and cosine unit
// Quadrant fold, a row of CORDIC cells, and the sign restore for three angles.
// ---------------------------------------------------------------------------
module erm_trig #(
    parameter int ANGLE_WIDTH = erm_pkg::ANGLE_WIDTH_DEF,
    parameter int TRIG_STAGES = erm_pkg::TRIG_STAGES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic signed [ANGLE_WIDTH-1:0] yaw_angle,
    input  wire logic signed [ANGLE_WIDTH-1:0] pitch_angle,
    input  wire logic signed [ANGLE_WIDTH-1:0] roll_angle,
    output logic                               out_valid,
    output erm_pkg::q30_t [2:0]                sin_val,
    output erm_pkg::q30_t [2:0]                cos_val
);

    localparam int NS = (TRIG_STAGES < erm_pkg::MAX_STAGES) ? TRIG_STAGES
                                                             : erm_pkg::MAX_STAGES;
    localparam int ASH = 33 - ANGLE_WIDTH;

    erm_pkg::q30_t [2:0]  ang;
    erm_pkg::cord_t [2:0] fold_next;
    erm_pkg::cord_t [2:0] fold_reg;
    logic                 fold_valid_reg;

    erm_pkg::cord_t [2:0] chain_data [0:NS];
    logic                 chain_valid [0:NS];

    erm_pkg::q30_t [2:0]  sin_reg;
    erm_pkg::q30_t [2:0]  sin_next;
    erm_pkg::q30_t [2:0]  cos_reg;
    erm_pkg::q30_t [2:0]  cos_next;
    logic                 out_valid_reg;

    assign ang[0] = erm_pkg::q30_t'(yaw_angle) <<< ASH;
    assign ang[1] = erm_pkg::q30_t'(pitch_angle) <<< ASH;
    assign ang[2] = erm_pkg::q30_t'(roll_angle) <<< ASH;

    // Angles outside the right half plane are moved by pi; the result is negated later.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            fold_next[k].x = erm_pkg::GAIN_Q30;
            fold_next[k].y = '0;
            if (ang[k] > erm_pkg::HALF_PI_Q30)
            begin
                fold_next[k].z    = ang[k] - erm_pkg::PI_Q30;
                fold_next[k].flip = 1'b1;
            end
            else if (ang[k] < -erm_pkg::HALF_PI_Q30)
            begin
                fold_next[k].z    = ang[k] + erm_pkg::PI_Q30;
                fold_next[k].flip = 1'b1;
            end
            else
            begin
                fold_next[k].z    = ang[k];
                fold_next[k].flip = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_valid_reg <= 1'b0;
        else
            fold_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        fold_reg <= fold_next;
    end

    assign chain_data[0]  = fold_reg;
    assign chain_valid[0] = fold_valid_reg;

    for (genvar g = 0; g < NS; g++)
    begin : g_cell
        erm_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (chain_data[NS][k].flip)
            begin
                sin_next[k] = -chain_data[NS][k].y;
                cos_next[k] = -chain_data[NS][k].x;
            end
            else
            begin
                sin_next[k] = chain_data[NS][k].y;
                cos_next[k] = chain_data[NS][k].x;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= chain_valid[NS];
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign out_valid = out_valid_reg;
    assign sin_val   = sin_reg;
    assign cos_val   = cos_reg;

endmodule
`default_nettype wire

// ===== design/erm_matrix.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Matrix element pipeline
// Forms the nine direction cosine elements from the sines and cosines.
// ---------------------------------------------------------------------------
module erm_matrix #(
    parameter int ELEMENT_FRAC_BITS = erm_pkg::ELEMENT_FRAC_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire erm_pkg::q30_t [2:0]  sin_val,
    input  wire erm_pkg::q30_t [2:0]  cos_val,
    output logic                      out_valid,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m00,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m01,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m02,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m10,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m11,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m12,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m20,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m21,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m22
);

    localparam int OW  = ELEMENT_FRAC_BITS + 2;
    localparam int SW  = erm_pkg::QW + 1;
    localparam int SH  = erm_pkg::QI - ELEMENT_FRAC_BITS;
    localparam int RSH = (SH > 0) ? SH - 1 : 0;
    localparam logic signed [SW-1:0] RND = (SH > 0) ? (35'sd1 <<< RSH) : 35'sd0;
    localparam logic signed [SW-1:0] LIM = 35'sd1 <<< ELEMENT_FRAC_BITS;

    typedef logic signed [SW-1:0] sum_t;
    typedef logic signed [OW-1:0] elem_t;

    function automatic elem_t to_out(input sum_t v);
        sum_t r;
        r = (v + RND) >>> SH;
        if (r > LIM)
            r = LIM;
        if (r < -LIM)
            r = -LIM;
        return r[OW-1:0];
    endfunction

    // Stage 1 products.
    logic          v1_reg;
    erm_pkg::q30_t sc_reg, ss_reg, p00_reg, p01_reg, n02_reg, p12_reg, p22_reg;
    erm_pkg::q30_t cph_sps_reg, sph_sps_reg, cph_cps_reg, sph_cps_reg;
    erm_pkg::q30_t sph_reg, cph_reg;

    // Stage 2 triple products.
    logic          v2_reg;
    erm_pkg::q30_t t10_reg, t11_reg, t20_reg, t21_reg;
    erm_pkg::q30_t q00_reg, q01_reg, q02_reg, q12_reg, q22_reg;
    erm_pkg::q30_t q_cph_sps_reg, q_sph_sps_reg, q_cph_cps_reg, q_sph_cps_reg;

    // Stage 3 rounded elements.
    logic          v3_reg;
    elem_t         e_reg [0:8];
    elem_t         e_next [0:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Lane 0 is yaw, lane 1 pitch, lane 2 roll.
    always_ff @(posedge clk)
    begin
        sc_reg      <= erm_pkg::mulq(sin_val[1], cos_val[0]);
        ss_reg      <= erm_pkg::mulq(sin_val[1], sin_val[0]);
        p00_reg     <= erm_pkg::mulq(cos_val[1], cos_val[0]);
        p01_reg     <= erm_pkg::mulq(cos_val[1], sin_val[0]);
        n02_reg     <= -sin_val[1];
        p12_reg     <= erm_pkg::mulq(sin_val[2], cos_val[1]);
        p22_reg     <= erm_pkg::mulq(cos_val[2], cos_val[1]);
        cph_sps_reg <= erm_pkg::mulq(cos_val[2], sin_val[0]);
        sph_sps_reg <= erm_pkg::mulq(sin_val[2], sin_val[0]);
        cph_cps_reg <= erm_pkg::mulq(cos_val[2], cos_val[0]);
        sph_cps_reg <= erm_pkg::mulq(sin_val[2], cos_val[0]);
        sph_reg     <= sin_val[2];
        cph_reg     <= cos_val[2];

        t10_reg       <= erm_pkg::mulq(sph_reg, sc_reg);
        t11_reg       <= erm_pkg::mulq(sph_reg, ss_reg);
        t20_reg       <= erm_pkg::mulq(cph_reg, sc_reg);
        t21_reg       <= erm_pkg::mulq(cph_reg, ss_reg);
        q00_reg       <= p00_reg;
        q01_reg       <= p01_reg;
        q02_reg       <= n02_reg;
        q12_reg       <= p12_reg;
        q22_reg       <= p22_reg;
        q_cph_sps_reg <= cph_sps_reg;
        q_sph_sps_reg <= sph_sps_reg;
        q_cph_cps_reg <= cph_cps_reg;
        q_sph_cps_reg <= sph_cps_reg;

        e_reg <= e_next;
    end

    always_comb
    begin
        e_next[0] = to_out(sum_t'(q00_reg));
        e_next[1] = to_out(sum_t'(q01_reg));
        e_next[2] = to_out(sum_t'(q02_reg));
        e_next[3] = to_out(sum_t'(t10_reg) - sum_t'(q_cph_sps_reg));
        e_next[4] = to_out(sum_t'(t11_reg) + sum_t'(q_cph_cps_reg));
        e_next[5] = to_out(sum_t'(q12_reg));
        e_next[6] = to_out(sum_t'(t20_reg) + sum_t'(q_sph_sps_reg));
        e_next[7] = to_out(sum_t'(t21_reg) - sum_t'(q_sph_cps_reg));
        e_next[8] = to_out(sum_t'(q22_reg));
    end

    assign out_valid = v3_reg;
    assign m00 = e_reg[0];
    assign m01 = e_reg[1];
    assign m02 = e_reg[2];
    assign m10 = e_reg[3];
    assign m11 = e_reg[4];
    assign m12 = e_reg[5];
    assign m20 = e_reg[6];
    assign m21 = e_reg[7];
    assign m22 = e_reg[8];

endmodule
`default_nettype wire

// ===== design/euler_angles_to_rotation_matrix_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Euler 3-2-1 rotation matrix
// Turns yaw, pitch and roll into the world-to-body direction cosine matrix.
// ---------------------------------------------------------------------------
// Usage:
//   Drive yaw_angle, pitch_angle and roll_angle and raise start. A transfer
//   takes place at each rising edge with start high and busy low. busy is
//   always low, so a new triple can be transferred in every cycle.
//   The nine elements appear together on m00..m22 for one cycle, marked by
//   done, after the fold, CORDIC, sign and matrix registers of the pipeline.
//   TRIG_STAGES is capped at 32.
//   The pipeline is the row of CORDIC cells, one micro-rotation per
//   cycle for all three angles, plus one fold stage, one sign stage and three
//   product and rounding stages. Throughput is one triple per cycle.
//   Results cannot be held off by the receiver; done must be sampled when it
//   is high. Reset clears all valid flags, so no done follows reset until a
//   new transfer.
// ---------------------------------------------------------------------------
module euler_angles_to_rotation_matrix_top #(
    parameter int ANGLE_WIDTH       = erm_pkg::ANGLE_WIDTH_DEF,
    parameter int ELEMENT_FRAC_BITS = erm_pkg::ELEMENT_FRAC_BITS_DEF,
    parameter int TRIG_STAGES       = erm_pkg::TRIG_STAGES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [ANGLE_WIDTH-1:0] yaw_angle,
    input  wire logic signed [ANGLE_WIDTH-1:0] pitch_angle,
    input  wire logic signed [ANGLE_WIDTH-1:0] roll_angle,
    output logic                               done,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m00,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m01,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m02,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m10,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m11,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m12,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m20,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m21,
    output logic signed [ELEMENT_FRAC_BITS+1:0] m22
);

    logic                trig_valid;
    erm_pkg::q30_t [2:0] sin_val;
    erm_pkg::q30_t [2:0] cos_val;

    assign busy = 1'b0;

    erm_trig #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .TRIG_STAGES (TRIG_STAGES)
    ) u_trig (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start & ~busy),
        .yaw_angle   (yaw_angle),
        .pitch_angle (pitch_angle),
        .roll_angle  (roll_angle),
        .out_valid   (trig_valid),
        .sin_val     (sin_val),
        .cos_val     (cos_val)
    );

    erm_matrix #(
        .ELEMENT_FRAC_BITS (ELEMENT_FRAC_BITS)
    ) u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trig_valid),
        .sin_val   (sin_val),
        .cos_val   (cos_val),
        .out_valid (done),
        .m00       (m00),
        .m01       (m01),
        .m02       (m02),
        .m10       (m10),
        .m11       (m11),
        .m12       (m12),
        .m20       (m20),
        .m21       (m21),
        .m22       (m22)
    );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// Euler rotation matrix testbench
// Sends yaw, pitch and roll triples in bursts with random gaps. A
// fixed-point CORDIC predictor computes the nine elements of each triple.
// Every done strobe is checked against the oldest predicted matrix.
// ---------------------------------------------------------------------------
module tb;

    localparam int AW       = 16;
    localparam int EF       = 14;
    localparam int OW       = EF + 2;
    localparam int STAGES   = 16;
    localparam int LATENCY  = STAGES + 5;
    localparam int WATCHDOG = 2000;
    localparam int NUM_RANDOM = 650;
    localparam int ANGLE_MAX  = 25736;

    typedef logic signed [63:0] q_t;
    typedef logic signed [OW-1:0] elem_t;
    typedef struct {
        elem_t m [9];
    } matrix_t;

    int error_count = 0;

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic q_t atan_entry(input int i);
        q_t tab [32] = '{843314856, 497837829, 263043836, 133525158, 66869110,
            33471835, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
            262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
            255, 127, 63, 31, 15, 8, 4, 2, 1, 0};
        return tab[i];
    endfunction

    function automatic q_t qmul(input q_t a, input q_t b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // Folds the angle into +/- pi/2, rotates, and negates when folded.
    function automatic void sin_cos(input logic signed [AW-1:0] ang, output q_t s,
            output q_t c);
        q_t z, x, y, nx;
        bit flip;
        z = q_t'(ang) <<< (30 - (AW - 3));
        x = 64'sd652032874;
        y = 0;
        flip = 0;
        if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426;
            flip = 1;
        end
        else if (z < -64'sd1686629713) begin
            z += 64'sd3373259426;
            flip = 1;
        end
        for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_entry(i);
            end
            else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_entry(i);
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic elem_t round_element(input q_t v);
        q_t r;
        r = (v + (64'sd1 <<< (30 - EF - 1))) >>> (30 - EF);
        if (r > (64'sd1 <<< EF)) r = 64'sd1 <<< EF;
        if (r < -(64'sd1 <<< EF)) r = -(64'sd1 <<< EF);
        return elem_t'(r);
    endfunction

    function automatic matrix_t predict_matrix(input logic signed [AW-1:0] yaw,
            input logic signed [AW-1:0] pitch, input logic signed [AW-1:0] roll);
        q_t sps, cps, sth, cth, sph, cph, sc, ss;
        matrix_t r;
        sin_cos(yaw, sps, cps);
        sin_cos(pitch, sth, cth);
        sin_cos(roll, sph, cph);
        sc = qmul(sth, cps);
        ss = qmul(sth, sps);
        r.m[0] = round_element(qmul(cth, cps));
        r.m[1] = round_element(qmul(cth, sps));
        r.m[2] = round_element(-sth);
        r.m[3] = round_element(qmul(sph, sc) - qmul(cph, sps));
        r.m[4] = round_element(qmul(sph, ss) + qmul(cph, cps));
        r.m[5] = round_element(qmul(sph, cth));
        r.m[6] = round_element(qmul(cph, sc) + qmul(sph, sps));
        r.m[7] = round_element(qmul(cph, ss) - qmul(sph, cps));
        r.m[8] = round_element(qmul(cph, cth));
        return r;
    endfunction

    class matrix_scoreboard;
        matrix_t pending [$];

        function void note_triple(input logic signed [AW-1:0] yaw,
                input logic signed [AW-1:0] pitch, input logic signed [AW-1:0] roll);
            pending.push_back(predict_matrix(yaw, pitch, roll));
        endfunction

        task check_matrix(input matrix_t got);
            matrix_t want;
            if (pending.size() == 0) begin
                report("result with no transfer pending");
                return;
            end
            want = pending.pop_front();
            for (int k = 0; k < 9; k++)
                if (got.m[k] !== want.m[k])
                    report($sformatf("m%0d%0d got %0d expected %0d",
                        k / 3, k % 3, got.m[k], want.m[k]));
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic signed [AW-1:0] yaw_angle = '0, pitch_angle = '0, roll_angle = '0;
    wire busy, done;
    wire signed [OW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    matrix_scoreboard sb = new();
    int idle_cycles = 0;

    euler_angles_to_rotation_matrix_top i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .yaw_angle(yaw_angle), .pitch_angle(pitch_angle), .roll_angle(roll_angle),
        .done(done), .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11),
        .m12(m12), .m20(m20), .m21(m21), .m22(m22)
    );

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    always @(posedge clk)
    begin
        matrix_t got;
        if (rst_n && start && !busy)
            sb.note_triple(yaw_angle, pitch_angle, roll_angle);
        if (rst_n && done) begin
            got.m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
            sb.check_matrix(got);
        end
        if ((start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Holds start high for one transfer, then leaves it high for the caller.
    task automatic send_triple(input logic signed [AW-1:0] yaw,
            input logic signed [AW-1:0] pitch, input logic signed [AW-1:0] roll);
        yaw_angle <= yaw;
        pitch_angle <= pitch;
        roll_angle <= roll;
        start <= 1;
        do @(posedge clk); while (busy);
    endtask

    function automatic logic signed [AW-1:0] random_angle();
        case ($urandom_range(0, 9))
            0: return AW'(ANGLE_MAX);
            1: return -AW'(ANGLE_MAX);
            2: return AW'($urandom_range(0, 40)) - AW'(20);
            default: return AW'(int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
        endcase
    endfunction

    initial
    begin
        logic signed [AW-1:0] corners [10];
        int sent;
        int burst;
        corners = '{AW'(0), AW'(ANGLE_MAX), -AW'(ANGLE_MAX), AW'(12868), -AW'(12868),
            AW'(12869), -AW'(12869), AW'(25735), AW'(1), -AW'(1)};
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // Corner angles: zero, limits, around +/- pi/2 and the range reduction edge.
        for (int k = 0; k < 10; k++)
            send_triple(corners[k], corners[(k + 3) % 10], corners[(k + 7) % 10]);
        send_triple(AW'(ANGLE_MAX), AW'(12868), AW'(0));
        send_triple(AW'(0), -AW'(12868), AW'(ANGLE_MAX));
        send_triple(-AW'(ANGLE_MAX), -AW'(ANGLE_MAX), -AW'(ANGLE_MAX));
        start <= 0;
        @(posedge clk);
        sent = 0;
        while (sent < NUM_RANDOM) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < NUM_RANDOM; k++) begin
                send_triple(random_angle(), random_angle(), random_angle());
                sent++;
            end
            start <= 0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30)) @(posedge clk);
        end
        start <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
